@@ rtl/core/pixel_blit_format_convert_defines.svh @@
// ---------------------------------------------------------------------------
// Pixel blit format convert: assertion macros
// Shared property wrappers for the blit core checks.
// ---------------------------------------------------------------------------
`ifndef PIXEL_BLIT_FORMAT_CONVERT_DEFINES_SVH
`define PIXEL_BLIT_FORMAT_CONVERT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PBFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define PBFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pbfc_pkg.sv @@
// ---------------------------------------------------------------------------
// pbfc_pkg
// Types, register codes and color scaling helpers for the blit core.
// ---------------------------------------------------------------------------
`default_nettype none

package pbfc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        FMT_RGB565   = 2'd0,
        FMT_RGBA8888 = 2'd1,
        FMT_ARGB8888 = 2'd2,
        FMT_RGBA5551 = 2'd3
    } t_pix_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIX_FMT       = 3'd0,
        CFG_ROTATE        = 3'd1,
        CFG_WINDOW_WIDTH  = 3'd2,
        CFG_WINDOW_HEIGHT = 3'd3,
        CFG_DEST_X        = 3'd4,
        CFG_DEST_Y        = 3'd5,
        CFG_MIRROR_ORIGIN = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_pix_fmt    pix_fmt;
        logic        rotate;
        logic [8:0]  win_w;
        logic [8:0]  win_h;
        logic [7:0]  dest_x;
        logic [7:0]  dest_y;
        logic [7:0]  mirror;
    } t_cfg;

    typedef struct packed {
        logic        we;
        logic [7:0]  x;
        logic [7:0]  y;
    } t_place;

    typedef struct packed {
        logic [7:0]  ch_r;
        logic [7:0]  ch_g;
        logic [7:0]  ch_b;
    } t_rgb;

    // v*255/31 truncated = 8v + floor(7v/31); the fraction steps at fixed v.
    function automatic logic [7:0] scale5(input logic [4:0] v);
        logic [2:0] k;
        if (v >= 5'd31)      k = 3'd7;
        else if (v >= 5'd27) k = 3'd6;
        else if (v >= 5'd23) k = 3'd5;
        else if (v >= 5'd18) k = 3'd4;
        else if (v >= 5'd14) k = 3'd3;
        else if (v >= 5'd9)  k = 3'd2;
        else if (v >= 5'd5)  k = 3'd1;
        else                 k = 3'd0;
        return {v, 3'b000} + {5'b00000, k};
    endfunction

    // v*255/63 truncated = 4v + floor(v/21).
    function automatic logic [7:0] scale6(input logic [5:0] v);
        logic [1:0] k;
        if (v >= 6'd63)      k = 2'd3;
        else if (v >= 6'd42) k = 2'd2;
        else if (v >= 6'd21) k = 2'd1;
        else                 k = 2'd0;
        return {v, 2'b00} + {6'b000000, k};
    endfunction

    // Zero acts as one, anything past 256 acts as 256.
    function automatic logic [8:0] clamp_size(input logic [8:0] v);
        if (v == 9'd0)        return 9'd1;
        else if (v > 9'd256)  return 9'd256;
        else                  return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pbfc_in_if.sv @@
// ---------------------------------------------------------------------------
// pbfc_in_if
// Raw pixel channel: valid/ready handshake with one source word.
// ---------------------------------------------------------------------------
`default_nettype none

interface pbfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_pixel;

    modport source (output valid, output raw_pixel, input ready);
    modport sink   (input valid, input raw_pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pbfc_out_if.sv @@
// ---------------------------------------------------------------------------
// pbfc_out_if
// Panel pixel channel: valid/ready handshake with placed, converted pixel.
// ---------------------------------------------------------------------------
`default_nettype none

interface pbfc_out_if;
    logic       valid;
    logic       ready;
    logic       write_enable;
    logic [7:0] out_x;
    logic [7:0] out_y;
    logic [7:0] ch_r;
    logic [7:0] ch_g;
    logic [7:0] ch_b;
    logic       frame_end;

    modport source (output valid, output write_enable, output out_x, output out_y,
                    output ch_r, output ch_g, output ch_b, output frame_end,
                    input ready);
    modport sink   (input valid, input write_enable, input out_x, input out_y,
                    input ch_r, input ch_g, input ch_b, input frame_end,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/pbfc_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// pbfc_cfg_regs
// Configuration register file; unknown indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module pbfc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pbfc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pbfc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output pbfc_pkg::t_cfg                        o_cfg
);

    pbfc_pkg::t_cfg r_cfg;
    pbfc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (pbfc_pkg::t_cfg_idx'(i_cfg_idx))
                pbfc_pkg::CFG_PIX_FMT:
                    n_cfg.pix_fmt = pbfc_pkg::t_pix_fmt'(i_cfg_data[1:0]);
                pbfc_pkg::CFG_ROTATE:        n_cfg.rotate = i_cfg_data[0];
                pbfc_pkg::CFG_WINDOW_WIDTH:  n_cfg.win_w  = i_cfg_data[8:0];
                pbfc_pkg::CFG_WINDOW_HEIGHT: n_cfg.win_h  = i_cfg_data[8:0];
                pbfc_pkg::CFG_DEST_X:        n_cfg.dest_x = i_cfg_data[7:0];
                pbfc_pkg::CFG_DEST_Y:        n_cfg.dest_y = i_cfg_data[7:0];
                pbfc_pkg::CFG_MIRROR_ORIGIN: n_cfg.mirror = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pix_fmt      <= pbfc_pkg::FMT_RGB565;
            r_cfg.rotate       <= 1'b0;
            r_cfg.win_w        <= 9'd1;
            r_cfg.win_h        <= 9'd1;
            r_cfg.dest_x       <= 8'd0;
            r_cfg.dest_y       <= 8'd0;
            r_cfg.mirror       <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/pbfc_raster_count.sv @@
// ---------------------------------------------------------------------------
// pbfc_raster_count
// Column and row counters over the source window.
// ---------------------------------------------------------------------------
`default_nettype none

module pbfc_raster_count (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_advance,
    input  wire logic [8:0]  i_win_w,
    input  wire logic [8:0]  i_win_h,
    output logic      [7:0]  o_col,
    output logic      [7:0]  o_row,
    output logic             o_last_col,
    output logic             o_last_row
);

    logic [7:0] r_col;
    logic [7:0] r_row;
    logic [7:0] n_col;
    logic [7:0] n_row;

    // A count past a shrunk window still counts as the last position.
    assign o_last_col = ({1'b0, r_col} + 9'd1) >= pbfc_pkg::clamp_size(i_win_w);
    assign o_last_row = ({1'b0, r_row} + 9'd1) >= pbfc_pkg::clamp_size(i_win_h);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (o_last_col) begin
                n_col = 8'd0;
                n_row = o_last_row ? 8'd0 : r_row + 8'd1;
            end else begin
                n_col = r_col + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 8'd0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col = r_col;
    assign o_row = r_row;

endmodule

`default_nettype wire

@@ rtl/core/pbfc_place.sv @@
// ---------------------------------------------------------------------------
// pbfc_place
// Map window position to panel coordinates, clip and mirror.
// ---------------------------------------------------------------------------
`default_nettype none

module pbfc_place #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  wire pbfc_pkg::t_cfg   i_cfg,
    input  wire logic [7:0]       i_col,
    input  wire logic [7:0]       i_row,
    output pbfc_pkg::t_place      o_place
);

    localparam logic [8:0] PanelW = 9'(PANEL_WIDTH);
    localparam logic [8:0] PanelH = 9'(PANEL_HEIGHT);

    logic [8:0] wx;
    logic [8:0] wy;
    logic [7:0] mx;
    logic       on_panel;

    always_comb begin
        wx       = {1'b0, i_cfg.dest_x} + {1'b0, i_col};
        wy       = {1'b0, i_cfg.dest_y} + {1'b0, i_row};
        mx       = i_cfg.mirror - wx[7:0];
        on_panel = (wx < PanelW) && (wy < PanelH);

        o_place.we = on_panel;
        o_place.x  = wx[7:0];
        o_place.y  = wy[7:0];
        if (on_panel && i_cfg.rotate) begin
            if (wx > {1'b0, i_cfg.mirror}) begin
                o_place.we = 1'b0;
            end else begin
                o_place.x = mx;
                if ({1'b0, mx} >= PanelW) o_place.we = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pbfc_color.sv @@
// ---------------------------------------------------------------------------
// pbfc_color
// Convert a source pixel word to 8-bit components.
// ---------------------------------------------------------------------------
`default_nettype none

module pbfc_color (
    input  wire pbfc_pkg::t_pix_fmt  i_fmt,
    input  wire logic [31:0]         i_pixel,
    output pbfc_pkg::t_rgb           o_rgb
);

    logic [15:0] half;

    assign half = i_pixel[15:0];

    always_comb begin
        case (i_fmt)
            pbfc_pkg::FMT_RGB565: begin
                o_rgb.ch_r = pbfc_pkg::scale5(half[15:11]);
                o_rgb.ch_g = pbfc_pkg::scale6(half[10:5]);
                o_rgb.ch_b = pbfc_pkg::scale5(half[4:0]);
            end
            pbfc_pkg::FMT_RGBA8888: begin
                o_rgb.ch_r = i_pixel[31:24];
                o_rgb.ch_g = i_pixel[23:16];
                o_rgb.ch_b = i_pixel[15:8];
            end
            pbfc_pkg::FMT_ARGB8888: begin
                o_rgb.ch_r = i_pixel[23:16];
                o_rgb.ch_g = i_pixel[15:8];
                o_rgb.ch_b = i_pixel[7:0];
            end
            default: begin
                o_rgb.ch_r = pbfc_pkg::scale5(half[15:11]);
                o_rgb.ch_g = pbfc_pkg::scale5(half[10:6]);
                o_rgb.ch_b = pbfc_pkg::scale5(half[5:1]);
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/pixel_blit_format_convert.sv @@
// ---------------------------------------------------------------------------
// pixel_blit_format_convert
// Raster blit: place, clip, mirror and color-convert a source pixel stream.
// ---------------------------------------------------------------------------
// Takes one source word per clock, barring back-pressure, in raster order
// over a window_width x window_height window, returning one panel word per
// source word in order; throughput is one word per clock while o_pix.ready
// is high. An input register feeds the result register, with the placement
// adder/comparators and the color scaling between them. The input side
// keeps taking words while a finished result waits at the output, until
// both registers are full. write_enable low means the pixel is off the
// panel (or mirrored off it) and the coordinate and color fields read zero;
// frame_end marks the last pixel of the window either way. Configuration
// writes belong in idle time only; they never touch the column/row count.
`default_nettype none

`include "pixel_blit_format_convert_defines.svh"

module pixel_blit_format_convert #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pbfc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pbfc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pbfc_in_if.sink                               i_pix,
    pbfc_out_if.source                            o_pix
);

    pbfc_pkg::t_cfg   cfg;
    pbfc_pkg::t_place place;
    pbfc_pkg::t_rgb   rgb;

    logic [7:0] col;
    logic [7:0] row;
    logic       last_col;
    logic       last_row;

    logic       in_acc;
    logic       s1_ready;
    logic       s2_ready;
    logic       s2_load;

    // Input register: the raw word and the window position it was taken at.
    logic        r_s1_valid;
    logic [31:0] r_s1_pixel;
    logic [7:0]  r_s1_col;
    logic [7:0]  r_s1_row;
    logic        r_s1_end;

    // Result register.
    logic        r_out_valid;
    logic        r_out_we;
    logic [7:0]  r_out_x;
    logic [7:0]  r_out_y;
    logic [7:0]  r_out_r;
    logic [7:0]  r_out_g;
    logic [7:0]  r_out_b;
    logic        r_out_end;

    logic        n_out_we;
    logic [7:0]  n_out_x;
    logic [7:0]  n_out_y;
    logic [7:0]  n_out_r;
    logic [7:0]  n_out_g;
    logic [7:0]  n_out_b;

    // Terms for the checks at the end.
    logic        out_clipped;
    logic        out_fields_zero;
    logic        frame_done;
    logic        raster_home;

    pbfc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Advance the raster position on every accepted word.
    pbfc_raster_count u_count (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (in_acc),
        .i_win_w    (cfg.win_w),
        .i_win_h    (cfg.win_h),
        .o_col      (col),
        .o_row      (row),
        .o_last_col (last_col),
        .o_last_row (last_row)
    );

    pbfc_place #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_place (
        .i_cfg   (cfg),
        .i_col   (r_s1_col),
        .i_row   (r_s1_row),
        .o_place (place)
    );

    pbfc_color u_color (
        .i_fmt   (cfg.pix_fmt),
        .i_pixel (r_s1_pixel),
        .o_rgb   (rgb)
    );

    // Each register fills when it is empty or its word leaves this cycle.
    assign s2_ready    = !r_out_valid || o_pix.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign s2_load     = r_s1_valid && s2_ready;
    assign in_acc      = i_pix.valid && s1_ready;
    assign i_pix.ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pixel <= i_pix.raw_pixel;
            r_s1_col   <= col;
            r_s1_row   <= row;
            r_s1_end   <= last_col && last_row;
        end
    end

    // Zero every coordinate and color field of a clipped pixel.
    always_comb begin
        n_out_we = place.we;
        n_out_x  = place.we ? place.x  : 8'd0;
        n_out_y  = place.we ? place.y  : 8'd0;
        n_out_r  = place.we ? rgb.ch_r : 8'd0;
        n_out_g  = place.we ? rgb.ch_g : 8'd0;
        n_out_b  = place.we ? rgb.ch_b : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_out_we  <= n_out_we;
            r_out_x   <= n_out_x;
            r_out_y   <= n_out_y;
            r_out_r   <= n_out_r;
            r_out_g   <= n_out_g;
            r_out_b   <= n_out_b;
            r_out_end <= r_s1_end;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.write_enable = r_out_we;
    assign o_pix.out_x        = r_out_x;
    assign o_pix.out_y        = r_out_y;
    assign o_pix.ch_r         = r_out_r;
    assign o_pix.ch_g         = r_out_g;
    assign o_pix.ch_b         = r_out_b;
    assign o_pix.frame_end    = r_out_end;

    assign out_clipped     = r_out_valid && !r_out_we;
    assign out_fields_zero = (r_out_x == 8'd0) && (r_out_y == 8'd0) && (r_out_r == 8'd0)
                             && (r_out_g == 8'd0) && (r_out_b == 8'd0);
    assign frame_done      = in_acc && last_col && last_row;
    assign raster_home     = (col == 8'd0) && (row == 8'd0);

    // A clipped word carries no coordinates or color.
    `PBFC_ASSERT_NOW(a_clip_zero, i_clk, i_rst_n, out_clipped, out_fields_zero, "clipped word not zero")

    // A word moving out of the input register lands in the result register.
    `PBFC_ASSERT_NEXT(a_s2_fill, i_clk, i_rst_n, s2_load, r_out_valid, "result register missed a word")

    // The last pixel of the window sends the raster position home.
    `PBFC_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, frame_done, raster_home, "raster count did not wrap")

endmodule

`default_nettype wire
